>>> hw/rtl/tla_pkg.sv
`default_nettype none
package tla_pkg;

  typedef enum logic [2:0] {
    ACT_TICK   = 3'd0,
    ACT_SAMPLE = 3'd1,
    ACT_SET    = 3'd2,
    ACT_DOWN   = 3'd3,
    ACT_UP     = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    MODE_RUN        = 2'd0,
    MODE_EDIT_UPPER = 2'd1,
    MODE_EDIT_LOWER = 2'd2
  } mode_t;

  localparam logic [6:0] UPPER_RESET  = 7'd38;
  localparam logic [6:0] LOWER_RESET  = 7'd5;
  localparam logic [6:0] LIMIT_MAX    = 7'd99;
  localparam logic [7:0] PERIOD_RESET = 8'd10;
  localparam logic [6:0] WHOLE_MAX    = 7'd99;
  localparam logic [3:0] TENTH_MAX    = 4'd9;
  localparam logic [14:0] TENTHS_MAX  = 15'd999;

  // Mode, limit and flag state seen by the top level
  typedef struct packed {
    mode_t      mode;
    logic [6:0] upper;
    logic [6:0] lower;
    logic       beep;
    logic       blink;
  } ctrl_stat_t;

endpackage
`default_nettype wire

>>> hw/rtl/tla_sample.sv
`default_nettype none
module tla_sample import tla_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               sample_en,
  input  wire logic signed [15:0] raw_temp,
  output logic             [6:0]  whole,
  output logic             [3:0]  tenth
);

  logic [6:0]  whole_r, whole_nxt;
  logic [3:0]  tenth_r, tenth_nxt;
  logic [18:0] prod10;
  logic [14:0] tenths;
  logic [9:0]  t10;
  logic [17:0] recip;
  logic [6:0]  q;
  logic [9:0]  q10;

  // tenths = floor((10*raw + 8) / 16) on the non-negative 15-bit magnitude
  assign prod10 = {1'b0, raw_temp[14:0], 3'b000} + {3'b000, raw_temp[14:0], 1'b0} + 19'd8;
  assign tenths = prod10[18:4];
  assign t10    = tenths[9:0];

  // divide by 10 via reciprocal, exact for t10 <= 999
  assign recip = {8'd0, t10} * 18'd205;
  assign q     = recip[17:11];
  assign q10   = {q, 3'b000} + {2'b00, q, 1'b0};

  always_comb begin
    whole_nxt = whole_r;
    tenth_nxt = tenth_r;
    if (sample_en) begin
      if (raw_temp[15]) begin
        whole_nxt = '0;
        tenth_nxt = '0;
      end else if (tenths > TENTHS_MAX) begin
        whole_nxt = WHOLE_MAX;
        tenth_nxt = TENTH_MAX;
      end else begin
        whole_nxt = q;
        tenth_nxt = 4'(t10 - q10);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      whole_r <= '0;
      tenth_r <= '0;
    end else begin
      whole_r <= whole_nxt;
      tenth_r <= tenth_nxt;
    end
  end

  assign whole = whole_r;
  assign tenth = tenth_r;

  a_whole_range: assert property (@(posedge clk) disable iff (!rst_n) whole_r <= WHOLE_MAX)
    else $error("whole degrees out of range");
  a_tenth_range: assert property (@(posedge clk) disable iff (!rst_n) tenth_r <= TENTH_MAX)
    else $error("tenth digit out of range");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !sample_en |=> $stable(whole_r) && $stable(tenth_r))
    else $error("temperature changed without a sample");

endmodule
`default_nettype wire

>>> hw/rtl/tla_ctrl.sv
`default_nettype none
module tla_ctrl import tla_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step_en,
  input  wire action_t    action,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  output ctrl_stat_t      stat
);

  logic [7:0] period_r;
  mode_t      mode_r, mode_nxt;
  logic [7:0] tick_r, tick_nxt;
  logic       beep_r, beep_nxt;
  logic       blink_r, blink_nxt;
  logic [6:0] upper_r, upper_nxt;
  logic [6:0] lower_r, lower_nxt;
  logic [7:0] tick_inc;

  assign tick_inc = tick_r + 8'd1;

  always_comb begin
    mode_nxt  = mode_r;
    tick_nxt  = tick_r;
    beep_nxt  = beep_r;
    blink_nxt = blink_r;
    upper_nxt = upper_r;
    lower_nxt = lower_r;
    if (step_en) begin
      case (action)
        ACT_TICK: begin
          tick_nxt = tick_inc;
          if (tick_inc >= period_r) begin
            tick_nxt = '0;
            if (mode_r == MODE_RUN) beep_nxt = ~beep_r;
            else                    blink_nxt = ~blink_r;
          end
        end
        ACT_SET: begin
          case (mode_r)
            MODE_RUN:        mode_nxt = MODE_EDIT_UPPER;
            MODE_EDIT_UPPER: mode_nxt = MODE_EDIT_LOWER;
            default:         mode_nxt = MODE_RUN;
          endcase
          tick_nxt  = '0;
          blink_nxt = 1'b1;
        end
        ACT_DOWN: begin
          if (mode_r == MODE_EDIT_UPPER) begin
            upper_nxt = (upper_r > lower_r) ? upper_r - 7'd1 : lower_r;
          end else if (mode_r == MODE_EDIT_LOWER) begin
            if (lower_r != '0) lower_nxt = lower_r - 7'd1;
          end
        end
        ACT_UP: begin
          if (mode_r == MODE_EDIT_UPPER) begin
            if (upper_r < LIMIT_MAX) upper_nxt = upper_r + 7'd1;
          end else if (mode_r == MODE_EDIT_LOWER) begin
            lower_nxt = (lower_r < upper_r) ? lower_r + 7'd1 : upper_r;
          end
        end
        default: ; // sample handled elsewhere; unused codes do nothing
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
      mode_r   <= MODE_RUN;
      tick_r   <= '0;
      beep_r   <= 1'b0;
      blink_r  <= 1'b0;
      upper_r  <= UPPER_RESET;
      lower_r  <= LOWER_RESET;
    end else begin
      if (cfg_wr_en) period_r <= cfg_wr_data;
      mode_r  <= mode_nxt;
      tick_r  <= tick_nxt;
      beep_r  <= beep_nxt;
      blink_r <= blink_nxt;
      upper_r <= upper_nxt;
      lower_r <= lower_nxt;
    end
  end

  assign stat.mode  = mode_r;
  assign stat.upper = upper_r;
  assign stat.lower = lower_r;
  assign stat.beep  = beep_r;
  assign stat.blink = blink_r;

  a_order: assert property (@(posedge clk) disable iff (!rst_n) upper_r >= lower_r)
    else $error("upper limit below lower limit");
  a_upper_max: assert property (@(posedge clk) disable iff (!rst_n) upper_r <= LIMIT_MAX)
    else $error("upper limit above maximum");
  a_set_blink: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && action == ACT_SET |=> blink_r && tick_r == '0)
    else $error("set key did not restart blink");

endmodule
`default_nettype wire

>>> hw/rtl/temperature_limit_alarm.sv
`default_nettype none
// An accepted transaction is registered at the input, then its update lands in
// the state/result registers once the result slot is free; result valid after it.
// Throughput: one transaction per cycle while the output register is not stalled.
// Reset (rst_n, synchronous, active low): run mode, limits 38/5, reading 0.0,
// flags and tick counter cleared, toggle period 10.
module temperature_limit_alarm import tla_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic        [2:0]  in_action,
  input  wire logic signed [15:0] in_raw_temp,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_alarm_on,
  output logic             [1:0]  out_mode,
  output logic             [6:0]  out_temp_whole,
  output logic             [3:0]  out_temp_tenth,
  output logic             [6:0]  out_upper_limit,
  output logic             [6:0]  out_lower_limit,
  output logic                    out_blink_visible,
  input  wire logic               cfg_wr_en,
  input  wire logic        [7:0]  cfg_wr_data
);

  // Input register: holds one transaction; skid-free since stall is simply
  // "input slot full and the result slot cannot take a new update".
  logic               in_valid_r, in_valid_nxt;
  action_t            action_r;
  logic signed [15:0] raw_r;
  logic               out_valid_r, out_valid_nxt;
  logic               advance;
  logic               step_en;
  logic               in_take;
  logic               sample_en;
  ctrl_stat_t         stat;
  logic [6:0]         whole;
  logic [3:0]         tenth;

  // The state registers double as the result register: they only change on
  // a step, and a step only happens when the previous result has gone.
  assign advance   = !out_valid_r || !out_stall;
  assign step_en   = in_valid_r && advance;
  assign in_stall  = in_valid_r && !advance;
  assign in_take   = in_valid && !in_stall;
  assign sample_en = step_en && action_r == ACT_SAMPLE && stat.mode == MODE_RUN;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take)      in_valid_nxt = 1'b1;
    else if (step_en) in_valid_nxt = 1'b0;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step_en)         out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      action_r <= action_t'(in_action);
      raw_r    <= in_raw_temp;
    end
  end

  tla_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (step_en),
    .action      (action_r),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .stat        (stat)
  );

  tla_sample u_sample (
    .clk       (clk),
    .rst_n     (rst_n),
    .sample_en (sample_en),
    .raw_temp  (raw_r),
    .whole     (whole),
    .tenth     (tenth)
  );

  // Alarm: run mode, beep phase on, reading outside [lower, upper)
  assign out_alarm_on      = stat.mode == MODE_RUN && stat.beep &&
                             (whole >= stat.upper || whole < stat.lower);
  assign out_valid         = out_valid_r;
  assign out_mode          = stat.mode;
  assign out_temp_whole    = whole;
  assign out_temp_tenth    = tenth;
  assign out_upper_limit   = stat.upper;
  assign out_lower_limit   = stat.lower;
  assign out_blink_visible = stat.mode != MODE_RUN && stat.blink;

  a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && out_valid_r && out_stall |-> in_stall)
    else $error("input accepted while result slot blocked");
  a_step_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    step_en |=> out_valid_r)
    else $error("step did not produce a result");
  a_state_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !step_en |=> $stable(stat) && $stable(whole) && $stable(tenth))
    else $error("state changed without a transaction");

endmodule
`default_nettype wire
